// File: hw/rtl/sos_pkg.sv
package sos_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_MID_PULSE      = 3'd0;
	localparam logic [2:0] REG_TRAVEL_MIN     = 3'd1;
	localparam logic [2:0] REG_TRAVEL_MAX     = 3'd2;
	localparam logic [2:0] REG_SCALE_POS      = 3'd3;
	localparam logic [2:0] REG_SCALE_NEG      = 3'd4;
	localparam logic [2:0] REG_REVERSED       = 3'd5;
	localparam logic [2:0] REG_MAX_STEP       = 3'd6;
	localparam logic [2:0] REG_OVERRIDE_LIMIT = 3'd7;

	// register reset values
	localparam logic [11:0]        MID_PULSE_RST      = 12'd1500;
	localparam logic signed [12:0] TRAVEL_MIN_RST     = -13'sd700;
	localparam logic [11:0]        TRAVEL_MAX_RST     = 12'd700;
	localparam logic [9:0]         SCALE_POS_RST      = 10'd500;
	localparam logic [9:0]         SCALE_NEG_RST      = 10'd500;
	localparam logic [31:0]        MAX_STEP_RST       = 32'd0;
	localparam logic [14:0]        OVERRIDE_LIMIT_RST = 15'd2000;

	// last pulse after reset: reset center pulse in Q16.16
	localparam logic signed [29:0] LAST_PULSE_RST = 30'sd98304000;

	// travel in thousandths of a microsecond: 10 bit scale times 17 bit command
	localparam int TRAVEL_W = 28;

	// floor(x / 125) for x below 2^22: (x * RECIP_125) >> RECIP_SHIFT, low by at most one
	localparam logic [22:0] RECIP_125   = 23'd4294967;
	localparam int          RECIP_SHIFT = 29;
	localparam logic [7:0]  DIV_K       = 8'd125;

	typedef struct packed {
		logic [11:0]        mid_pulse;
		logic signed [12:0] travel_min;
		logic [11:0]        travel_max;
		logic [9:0]         scale_pos;
		logic [9:0]         scale_neg;
		logic               reversed;
		logic [31:0]        max_step;
		logic [14:0]        override_limit;
	} cfg_t;

	// one classified request between front and back
	typedef struct packed {
		logic signed [TRAVEL_W-1:0] travel;
		logic                       override_used;
	} sos_item_t;

endpackage

// File: hw/rtl/sos_front.sv
module sos_front (
	input  logic                clk,
	input  logic                arst_n,
	input  sos_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  mixer_command,
	input  logic signed [15:0]  override_value,
	input  logic                armed,
	output logic                push_valid,
	output sos_pkg::sos_item_t  push_item,
	input  logic                push_ready
);

	logic               valid_s1;
	sos_pkg::sos_item_t item_s1;

	logic signed [16:0] lim;
	logic signed [16:0] ovr;
	logic               use_ovr;
	logic signed [16:0] cmd_sel;
	logic signed [16:0] cmd;
	logic [9:0]         scale;
	logic signed [27:0] travel;

	// pick the command source, reverse it if set, and scale it
	always_comb begin
		lim     = $signed({2'b00, cfg.override_limit});
		ovr     = {override_value[15], override_value};
		use_ovr = !armed && (ovr >= -lim) && (ovr <= lim);
		cmd_sel = use_ovr ? ovr : {mixer_command[15], mixer_command};
		cmd     = cfg.reversed ? -cmd_sel : cmd_sel;
		scale   = cmd[16] ? cfg.scale_neg : cfg.scale_pos;
		travel  = $signed({1'b0, scale}) * cmd;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// hold the classified request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.travel        <= travel[sos_pkg::TRAVEL_W-1:0];
			item_s1.override_used <= use_ovr;
		end
	end

endmodule

// File: hw/rtl/sos_queue.sv
module sos_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  sos_pkg::sos_item_t push_item,
	output logic               pop_valid,
	input  logic               pop,
	output sos_pkg::sos_item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	sos_pkg::sos_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// store the request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("queue count missed a pop");

endmodule

// File: hw/rtl/sos_back.sv
module sos_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sos_pkg::cfg_t       cfg,
	input  logic                pop_valid,
	output logic                pop,
	input  sos_pkg::sos_item_t  pop_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [29:0]  pulse_q16,
	output logic                travel_saturated,
	output logic                override_used
);

	localparam int TW = sos_pkg::TRAVEL_W;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_q;

	// stage 1: clamp test and first reciprocal product
	logic [21:0]        mag_s1;
	logic [15:0]        est_s1;
	logic               neg_s1, sat_s1, ovr_s1;
	logic signed [29:0] clamp_s1;
	// stage 2: quotient by 125 and second reciprocal product
	logic [15:0]        hi_s2;
	logic [19:0]        y_s2;
	logic [13:0]        est_s2;
	logic               neg_s2, sat_s2, ovr_s2;
	logic signed [29:0] clamp_s2;
	// stage 3: new pulse before slew limit
	logic signed [29:0] pulse_s3;
	logic               sat_s3, ovr_s3;
	// output and state
	logic signed [29:0] pulse_q, last_pulse_q;
	logic               sat_q, ovr_q;

	logic signed [TW-1:0] tv;
	logic signed [TW-1:0] max_k, min_k;
	logic [TW-1:0]        abs_tv;
	logic [44:0]          prod1;
	logic                 over_max, under_min;

	logic [21:0]  rem1;
	logic [15:0]  hi1;
	logic [7:0]   r1;
	logic [19:0]  y1;
	logic [42:0]  prod2;

	logic [19:0]        rem2;
	logic [13:0]        lo2;
	logic [29:0]        qmag;
	logic signed [29:0] qval;
	logic signed [29:0] pulse_new;

	logic signed [33:0] d34, ms34, slew34;

	assign en  = !(valid_q && !out_ready);
	assign pop = en && pop_valid;

	// stage 1 logic
	always_comb begin
		tv        = pop_item.travel;
		max_k     = $signed({{(TW-12){1'b0}}, cfg.travel_max}) * TW'(1000);
		min_k     = $signed({{(TW-13){cfg.travel_min[12]}}, cfg.travel_min}) * TW'(1000);
		over_max  = tv > max_k;
		under_min = tv < min_k;
		abs_tv    = tv[TW-1] ? TW'(-tv) : TW'(tv);
		prod1     = {23'd0, abs_tv[21:0]} * {22'd0, sos_pkg::RECIP_125};
	end

	// stage 2 logic: correct the quotient estimate once
	always_comb begin
		rem1 = mag_s1 - 22'(est_s1) * 22'(sos_pkg::DIV_K);
		if (rem1 >= 22'(sos_pkg::DIV_K)) begin
			hi1 = est_s1 + 16'd1;
			r1  = 8'(rem1 - 22'(sos_pkg::DIV_K));
		end else begin
			hi1 = est_s1;
			r1  = rem1[7:0];
		end
		y1    = {r1[6:0], 13'd0} + 20'd62;
		prod2 = {23'd0, y1} * {20'd0, sos_pkg::RECIP_125};
	end

	// stage 3 logic: finish rounding, restore sign or take the clamp, add center
	always_comb begin
		rem2 = y_s2 - 20'(est_s2) * 20'(sos_pkg::DIV_K);
		lo2  = (rem2 >= 20'(sos_pkg::DIV_K)) ? est_s2 + 14'd1 : est_s2;
		qmag = {1'b0, hi_s2, 13'd0} + {16'd0, lo2};
		qval = neg_s2 ? -$signed(qmag) : $signed(qmag);
		if (sat_s2) begin
			qval = clamp_s2;
		end
		pulse_new = $signed({2'b00, cfg.mid_pulse, 16'd0}) + qval;
	end

	// slew limit against the last output
	always_comb begin
		d34    = 34'(pulse_s3) - 34'(last_pulse_q);
		ms34   = $signed({2'b00, cfg.max_step});
		slew34 = 34'(pulse_s3);
		if (cfg.max_step != '0) begin
			if (d34 > ms34) begin
				slew34 = 34'(last_pulse_q) + ms34;
			end else if (d34 < -ms34) begin
				slew34 = 34'(last_pulse_q) - ms34;
			end
		end
	end

	// advance stage valids and state when the output is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_q      <= 1'b0;
			last_pulse_q <= sos_pkg::LAST_PULSE_RST;
		end else if (en) begin
			valid_s1 <= pop_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_q  <= valid_s3;
			if (valid_s3) begin
				last_pulse_q <= slew34[29:0];
			end
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= abs_tv[21:0];
			est_s1   <= prod1[sos_pkg::RECIP_SHIFT +: 16];
			neg_s1   <= tv[TW-1];
			sat_s1   <= over_max || under_min;
			ovr_s1   <= pop_item.override_used;
			clamp_s1 <= over_max ? $signed({2'b00, cfg.travel_max, 16'd0})
				: $signed({cfg.travel_min[12], cfg.travel_min, 16'd0});

			hi_s2    <= hi1;
			y_s2     <= y1;
			est_s2   <= prod2[sos_pkg::RECIP_SHIFT +: 14];
			neg_s2   <= neg_s1;
			sat_s2   <= sat_s1;
			ovr_s2   <= ovr_s1;
			clamp_s2 <= clamp_s1;

			pulse_s3 <= pulse_new;
			sat_s3   <= sat_s2;
			ovr_s3   <= ovr_s2;

			pulse_q  <= slew34[29:0];
			sat_q    <= sat_s3;
			ovr_q    <= ovr_s3;
		end
	end

	assign out_valid        = valid_q;
	assign pulse_q16        = pulse_q;
	assign travel_saturated = sat_q;
	assign override_used    = ovr_q;

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> $stable(last_pulse_q))
		else $error("last pulse moved during output stall");

	a_slew_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s3 && cfg.max_step != '0) |=>
		((34'(last_pulse_q) - 34'($past(last_pulse_q)) <= $signed({2'b00, cfg.max_step})) &&
		 (34'(last_pulse_q) - 34'($past(last_pulse_q)) >= -$signed({2'b00, cfg.max_step}))))
		else $error("pulse step beyond max_step");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s3) |=> (pulse_q == last_pulse_q))
		else $error("output pulse differs from kept state");

endmodule

// File: hw/rtl/servo_output_shaper.sv
// Servo output shaper: one servo channel, one request per control tick.
// Path: front register, queue, back stages 1 to 3 and the output register.
// Throughput: one request per cycle unless out_ready stalls; the reciprocal divide
// by 125 spans three back stages, the slew compare on the last pulse takes one.
// Reset: registers return to their defaults, the queue empties and the last
// pulse restarts at the default center pulse.
module servo_output_shaper #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] mixer_command,
	input  logic signed [15:0] override_value,
	input  logic               armed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [29:0] pulse_q16,
	output logic               travel_saturated,
	output logic               override_used
);

	sos_pkg::cfg_t      cfg_q;
	logic               push_valid, push_ready;
	sos_pkg::sos_item_t push_item;
	logic               pop_valid, pop;
	sos_pkg::sos_item_t pop_item;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mid_pulse      <= sos_pkg::MID_PULSE_RST;
			cfg_q.travel_min     <= sos_pkg::TRAVEL_MIN_RST;
			cfg_q.travel_max     <= sos_pkg::TRAVEL_MAX_RST;
			cfg_q.scale_pos      <= sos_pkg::SCALE_POS_RST;
			cfg_q.scale_neg      <= sos_pkg::SCALE_NEG_RST;
			cfg_q.reversed       <= 1'b0;
			cfg_q.max_step       <= sos_pkg::MAX_STEP_RST;
			cfg_q.override_limit <= sos_pkg::OVERRIDE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sos_pkg::REG_MID_PULSE:      cfg_q.mid_pulse      <= cfg_wdata[11:0];
				sos_pkg::REG_TRAVEL_MIN:     cfg_q.travel_min     <= $signed(cfg_wdata[12:0]);
				sos_pkg::REG_TRAVEL_MAX:     cfg_q.travel_max     <= cfg_wdata[11:0];
				sos_pkg::REG_SCALE_POS:      cfg_q.scale_pos      <= cfg_wdata[9:0];
				sos_pkg::REG_SCALE_NEG:      cfg_q.scale_neg      <= cfg_wdata[9:0];
				sos_pkg::REG_REVERSED:       cfg_q.reversed       <= cfg_wdata[0];
				sos_pkg::REG_MAX_STEP:       cfg_q.max_step       <= cfg_wdata;
				sos_pkg::REG_OVERRIDE_LIMIT: cfg_q.override_limit <= cfg_wdata[14:0];
				default: begin
				end
			endcase
		end
	end

	sos_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mixer_command  (mixer_command),
		.override_value (override_value),
		.armed          (armed),
		.push_valid     (push_valid),
		.push_item      (push_item),
		.push_ready     (push_ready)
	);

	sos_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	sos_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.pop_valid        (pop_valid),
		.pop              (pop),
		.pop_item         (pop_item),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pulse_q16        (pulse_q16),
		.travel_saturated (travel_saturated),
		.override_used    (override_used)
	);

endmodule

// File: tb/sv/servo_output_shaper_tb.sv
module servo_output_shaper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_OFF_LEN  = 200;
	localparam int PRINT_CAP     = 40;

	typedef struct {
		logic signed [29:0] pulse_q16;
		logic               travel_saturated;
		logic               override_used;
	} pulse_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] mixer_command;
	logic signed [15:0] override_value;
	logic               armed;
	logic               out_valid;
	logic               out_ready;
	logic signed [29:0] pulse_q16;
	logic               travel_saturated;
	logic               override_used;

	// shadow of the block: register file and last pulse
	sos_pkg::cfg_t      shaper_cfg;
	logic signed [29:0] last_pulse_q16;
	pulse_result_t      pending_pulses[$];

	int error_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;

	servo_output_shaper dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mixer_command    (mixer_command),
		.override_value   (override_value),
		.armed            (armed),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pulse_q16        (pulse_q16),
		.travel_saturated (travel_saturated),
		.override_used    (override_used)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// shape one tick: select, reverse, scale, clamp, center, slew limit
	function automatic pulse_result_t shape_pulse(input logic signed [15:0] mix,
			input logic signed [15:0] ovr, input logic arm);
		pulse_result_t res;
		longint        lim;
		longint        cmd;
		longint        gain;
		longint        travel;
		longint        scaled;
		longint        offset;
		longint        pulse;
		longint        prev;
		longint        step;
		longint        t_min;
		longint        t_max;
		lim = longint'(shaper_cfg.override_limit);
		res.override_used = !arm && (longint'(ovr) >= -lim) && (longint'(ovr) <= lim);
		cmd = res.override_used ? longint'(ovr) : longint'(mix);
		if (shaper_cfg.reversed)
			cmd = -cmd;
		gain = (cmd >= 0) ? longint'(shaper_cfg.scale_pos) : longint'(shaper_cfg.scale_neg);
		travel = gain * cmd;
		t_max = longint'(shaper_cfg.travel_max);
		t_min = longint'($signed(shaper_cfg.travel_min));
		res.travel_saturated = 1'b1;
		if (travel > t_max * 1000) begin
			offset = t_max * 65536;
		end else if (travel < t_min * 1000) begin
			offset = t_min * 65536;
		end else begin
			// thousandths of a microsecond to Q16.16, nearest, ties away from zero
			res.travel_saturated = 1'b0;
			scaled = travel * 65536;
			if (scaled >= 0)
				offset = (scaled + 500) / 1000;
			else
				offset = -((-scaled + 500) / 1000);
		end
		pulse = longint'(shaper_cfg.mid_pulse) * 65536 + offset;
		prev = longint'(last_pulse_q16);
		step = longint'(shaper_cfg.max_step);
		if (step != 0) begin
			if (pulse - prev > step)
				pulse = prev + step;
			else if (pulse - prev < -step)
				pulse = prev - step;
		end
		last_pulse_q16 = pulse[29:0];
		res.pulse_q16 = pulse[29:0];
		return res;
	endfunction

	// receiver: hold off on request, otherwise stall at random
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ready = 1'b0;
			hold_off_cycles--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each delivered result with the oldest prediction
	always @(posedge clk) begin : check_results
		pulse_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pulses.size() == 0) begin
				report_mismatch("result with nothing pending", longint'(pulse_q16), 0);
			end else begin
				want = pending_pulses.pop_front();
				if (pulse_q16 !== want.pulse_q16)
					report_mismatch("pulse_q16", longint'(pulse_q16), longint'(want.pulse_q16));
				if (travel_saturated !== want.travel_saturated)
					report_mismatch("travel_saturated", longint'(travel_saturated),
						longint'(want.travel_saturated));
				if (override_used !== want.override_used)
					report_mismatch("override_used", longint'(override_used),
						longint'(want.override_used));
			end
		end
	end

	// write one register; call at a falling edge with the block idle
	task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_wdata = data;
		case (index)
			sos_pkg::REG_MID_PULSE:      shaper_cfg.mid_pulse = data[11:0];
			sos_pkg::REG_TRAVEL_MIN:     shaper_cfg.travel_min = data[12:0];
			sos_pkg::REG_TRAVEL_MAX:     shaper_cfg.travel_max = data[11:0];
			sos_pkg::REG_SCALE_POS:      shaper_cfg.scale_pos = data[9:0];
			sos_pkg::REG_SCALE_NEG:      shaper_cfg.scale_neg = data[9:0];
			sos_pkg::REG_REVERSED:       shaper_cfg.reversed = data[0];
			sos_pkg::REG_MAX_STEP:       shaper_cfg.max_step = data;
			sos_pkg::REG_OVERRIDE_LIMIT: shaper_cfg.override_limit = data[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// offer one tick request; returns at the falling edge after acceptance
	task automatic send_tick(input logic signed [15:0] mix, input logic signed [15:0] ovr,
			input logic arm);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		mixer_command = mix;
		override_value = ovr;
		armed = arm;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pending_pulses.push_back(shape_pulse(mix, ovr, arm));
		@(negedge clk);
	endtask

	// drop valid and wait until every predicted result has come back
	task automatic wait_for_results();
		in_valid = 1'b0;
		while (pending_pulses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_tick();
		longint lim;
		longint lo;
		longint hi;
		logic signed [15:0] mix;
		logic signed [15:0] ovr;
		if ($urandom_range(99) < 45)
			mix = 16'(int'($urandom_range(0, 4000)) - 2000);
		else
			mix = 16'($urandom);
		if ($urandom_range(99) < 50) begin
			// within the override window widened by two on each side
			lim = longint'(shaper_cfg.override_limit);
			lo = (-lim - 2 < -32768) ? -32768 : -lim - 2;
			hi = (lim + 2 > 32767) ? 32767 : lim + 2;
			ovr = 16'(lo + longint'($urandom_range(0, int'(hi - lo))));
		end else begin
			ovr = 16'($urandom);
		end
		send_tick(mix, ovr, 1'($urandom_range(1)));
	endtask

	// load all registers: 0 random, 1 upper extremes, 2 lower extremes
	task automatic load_shaper_cfg(input int flavor);
		int r;
		case (flavor)
			1: begin
				write_reg(sos_pkg::REG_MID_PULSE, 32'd4095);
				write_reg(sos_pkg::REG_TRAVEL_MIN, 32'd0);
				write_reg(sos_pkg::REG_TRAVEL_MAX, 32'd4095);
				write_reg(sos_pkg::REG_SCALE_POS, 32'd1023);
				write_reg(sos_pkg::REG_SCALE_NEG, 32'd1023);
				write_reg(sos_pkg::REG_REVERSED, 32'd1);
				write_reg(sos_pkg::REG_MAX_STEP, 32'hFFFF_FFFF);
				write_reg(sos_pkg::REG_OVERRIDE_LIMIT, 32'd32767);
			end
			2: begin
				write_reg(sos_pkg::REG_MID_PULSE, 32'd0);
				write_reg(sos_pkg::REG_TRAVEL_MIN, 32'(-4096));
				write_reg(sos_pkg::REG_TRAVEL_MAX, 32'd0);
				write_reg(sos_pkg::REG_SCALE_POS, 32'd0);
				write_reg(sos_pkg::REG_SCALE_NEG, 32'($urandom_range(0, 1000)));
				write_reg(sos_pkg::REG_REVERSED, 32'd0);
				write_reg(sos_pkg::REG_MAX_STEP, 32'd1);
				write_reg(sos_pkg::REG_OVERRIDE_LIMIT, 32'd0);
			end
			default: begin
				write_reg(sos_pkg::REG_MID_PULSE, 32'($urandom_range(0, 4095)));
				if ($urandom_range(99) < 80)
					write_reg(sos_pkg::REG_TRAVEL_MIN, 32'(-int'($urandom_range(0, 4095))));
				else
					write_reg(sos_pkg::REG_TRAVEL_MIN, $urandom);
				write_reg(sos_pkg::REG_TRAVEL_MAX, 32'($urandom_range(0, 4095)));
				write_reg(sos_pkg::REG_SCALE_POS,
					32'($urandom_range(0, ($urandom_range(99) < 85) ? 1000 : 1023)));
				write_reg(sos_pkg::REG_SCALE_NEG,
					32'($urandom_range(0, ($urandom_range(99) < 85) ? 1000 : 1023)));
				write_reg(sos_pkg::REG_REVERSED, 32'($urandom_range(1)));
				r = $urandom_range(99);
				if (r < 35)
					write_reg(sos_pkg::REG_MAX_STEP, 32'd0);
				else if (r < 80)
					write_reg(sos_pkg::REG_MAX_STEP, 32'($urandom_range(1, 40 * 65536)));
				else
					write_reg(sos_pkg::REG_MAX_STEP, $urandom);
				if ($urandom_range(99) < 70)
					write_reg(sos_pkg::REG_OVERRIDE_LIMIT, 32'($urandom_range(0, 3000)));
				else
					write_reg(sos_pkg::REG_OVERRIDE_LIMIT, 32'($urandom_range(0, 32767)));
			end
		endcase
	endtask

	// default registers: zero command, clamp edges, override window
	task automatic test_reset_defaults();
		send_tick(16'sd0, 16'sd32767, 1'b1);
		send_tick(16'sd1400, 16'sd0, 1'b1);
		send_tick(16'sd1401, 16'sd0, 1'b1);
		send_tick(-16'sd1401, 16'sd0, 1'b1);
		send_tick(16'sd32767, 16'sd0, 1'b1);
		send_tick(-16'sd32768, 16'sd0, 1'b1);
		send_tick(16'sd5, 16'sd2000, 1'b0);
		send_tick(16'sd7, -16'sd2001, 1'b0);
		send_tick(16'sd7, -16'sd2000, 1'b0);
		send_tick(-16'sd7, 16'sd3, 1'b1);
		wait_for_results();
	endtask

	task automatic test_special_cases();
		// reversed full-scale negative must not wrap
		write_reg(sos_pkg::REG_REVERSED, 32'd1);
		send_tick(-16'sd32768, 16'sd0, 1'b1);
		send_tick(16'sd1000, 16'sd0, 1'b1);
		wait_for_results();
		// travel of +-4095, widest positive gain, zero negative gain
		write_reg(sos_pkg::REG_REVERSED, 32'd0);
		write_reg(sos_pkg::REG_SCALE_POS, 32'd1023);
		write_reg(sos_pkg::REG_SCALE_NEG, 32'd0);
		write_reg(sos_pkg::REG_TRAVEL_MAX, 32'd4095);
		write_reg(sos_pkg::REG_TRAVEL_MIN, 32'(-4095));
		write_reg(sos_pkg::REG_MID_PULSE, 32'd4095);
		send_tick(16'sd4003, 16'sd0, 1'b1);
		send_tick(16'sd32767, 16'sd0, 1'b1);
		send_tick(-16'sd32768, 16'sd0, 1'b1);
		wait_for_results();
		// negative output pulse
		write_reg(sos_pkg::REG_MID_PULSE, 32'd0);
		write_reg(sos_pkg::REG_SCALE_NEG, 32'd1000);
		send_tick(-16'sd32768, 16'sd0, 1'b1);
		wait_for_results();
		// travel_min above travel_max: min clamp alone, then both hit and max wins
		write_reg(sos_pkg::REG_TRAVEL_MIN, 32'd300);
		write_reg(sos_pkg::REG_TRAVEL_MAX, 32'd100);
		write_reg(sos_pkg::REG_SCALE_POS, 32'd1000);
		send_tick(16'sd50, 16'sd0, 1'b1);
		send_tick(16'sd200, 16'sd0, 1'b1);
		wait_for_results();
		// override window at both extremes
		write_reg(sos_pkg::REG_OVERRIDE_LIMIT, 32'd0);
		send_tick(16'sd9, 16'sd0, 1'b0);
		send_tick(16'sd9, 16'sd1, 1'b0);
		wait_for_results();
		write_reg(sos_pkg::REG_OVERRIDE_LIMIT, 32'd32767);
		send_tick(16'sd9, -16'sd32768, 1'b0);
		send_tick(16'sd9, 16'sd32767, 1'b0);
		wait_for_results();
		// slew limit: small step both ways, then the largest step
		write_reg(sos_pkg::REG_TRAVEL_MIN, 32'(-700));
		write_reg(sos_pkg::REG_TRAVEL_MAX, 32'd700);
		write_reg(sos_pkg::REG_MID_PULSE, 32'd1500);
		write_reg(sos_pkg::REG_MAX_STEP, 32'd65536);
		send_tick(16'sd700, 16'sd0, 1'b1);
		send_tick(-16'sd700, 16'sd0, 1'b1);
		wait_for_results();
		write_reg(sos_pkg::REG_MAX_STEP, 32'hFFFF_FFFF);
		send_tick(16'sd333, 16'sd0, 1'b1);
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int flavor, input int count);
		load_shaper_cfg(flavor);
		repeat (count) send_random_tick();
		wait_for_results();
	endtask

	// hold the receiver off while requests keep coming, so the input stalls
	task automatic test_backpressure_fill();
		load_shaper_cfg(0);
		@(posedge clk);
		hold_off_cycles = HOLD_OFF_LEN;
		@(negedge clk);
		repeat (40) send_random_tick();
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sos_pkg::REG_MID_PULSE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mixer_command = '0;
		override_value = '0;
		armed = 1'b0;
		out_ready = 1'b0;
		error_count = 0;
		cycle_count = 0;
		hold_off_cycles = 0;
		send_idle_pct = 10;
		recv_stall_pct = 60;
		shaper_cfg.mid_pulse = sos_pkg::MID_PULSE_RST;
		shaper_cfg.travel_min = sos_pkg::TRAVEL_MIN_RST;
		shaper_cfg.travel_max = sos_pkg::TRAVEL_MAX_RST;
		shaper_cfg.scale_pos = sos_pkg::SCALE_POS_RST;
		shaper_cfg.scale_neg = sos_pkg::SCALE_NEG_RST;
		shaper_cfg.reversed = 1'b0;
		shaper_cfg.max_step = sos_pkg::MAX_STEP_RST;
		shaper_cfg.override_limit = sos_pkg::OVERRIDE_LIMIT_RST;
		last_pulse_q16 = sos_pkg::LAST_PULSE_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_reset_defaults();
		test_special_cases();

		test_random_traffic(1, 118);
		test_random_traffic(0, 118);
		test_backpressure_fill();

		send_idle_pct = 60;
		recv_stall_pct = 10;
		test_random_traffic(2, 118);
		test_random_traffic(0, 118);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(0, 118);
		test_random_traffic(0, 118);

		if (pending_pulses.size() != 0)
			report_mismatch("results never delivered", 0, pending_pulses.size());
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/sos_pkg.sv
hw/rtl/sos_front.sv
hw/rtl/sos_queue.sv
hw/rtl/sos_back.sv
hw/rtl/servo_output_shaper.sv
tb/sv/servo_output_shaper_tb.sv
